FILE: rtl/core/sip_pkg.sv
`default_nettype none
package sip_pkg;

  localparam int CoordW = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] a0_x;
    logic signed [CoordW-1:0] a0_y;
    logic signed [CoordW-1:0] a1_x;
    logic signed [CoordW-1:0] a1_y;
    logic signed [CoordW-1:0] b0_x;
    logic signed [CoordW-1:0] b0_y;
    logic signed [CoordW-1:0] b1_x;
    logic signed [CoordW-1:0] b1_y;
  } sip_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] cross_x;
    logic signed [CoordW-1:0] cross_y;
  } sip_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/segment_intersection_point_unit.sv
`default_nettype none
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  sip_in_t  (two segments)
// out_     output     out_valid/out_stall sip_out_t (hit, point)
// One item enters per cycle while no stalled result is held at the output.
// The tail is a restoring divider, one quotient bit per stage.
// Reset clears the valid bits only; data registers are not reset.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module segment_intersection_point_unit
  import sip_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sip_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sip_out_t      out_data
);

  localparam int W  = CoordW;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int XW = 3 * W + 3;
  localparam int NV = 6 + W;

  logic adv;
  logic [NV-1:0] v_r;
  logic out_valid_r;
  sip_out_t out_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: differences
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r, ox_r, oy_r;
  logic signed [W-1:0]  a0x1_r, a0y1_r;
  // stage 2: products
  logic signed [PW-1:0] p_dd0_r, p_dd1_r, p_t0_r, p_t1_r, p_s0_r, p_s1_r;
  logic signed [DW-1:0] dax2_r, day2_r;
  logic signed [W-1:0]  a0x2_r, a0y2_r;
  // stage 3: den and numerators
  logic signed [NW-1:0] den3_r, nt3_r, ns3_r;
  logic signed [DW-1:0] dax3_r, day3_r;
  logic signed [W-1:0]  a0x3_r, a0y3_r;
  // stage 4: normalise and test
  logic signed [NW-1:0] den4_r, nt4_r;
  logic                 hit4_r;
  logic signed [DW-1:0] dax4_r, day4_r;
  logic signed [W-1:0]  a0x4_r, a0y4_r;
  // stage 5: coordinate products
  logic signed [XW-1:0] mx0_r, mx1_r, my0_r, my1_r;
  logic signed [NW-1:0] den5_r;
  logic                 hit5_r;
  // divider pipeline, index 0 is stage 6
  logic [XW-1:0] rx_r [W+1];
  logic [XW-1:0] ry_r [W+1];
  logic [W-1:0]  qx_r [W+1];
  logic [W-1:0]  qy_r [W+1];
  logic [XW-1:0] dd_r [W+1];
  logic          nx_r [W+1];
  logic          ny_r [W+1];
  logic          hd_r [W+1];

  logic signed [NW-1:0] den_n, nt_n, ns_n, dmt, dms;
  logic                 neg3, hit_n;
  logic signed [XW-1:0] sx, sy;

  always_comb begin
    neg3  = den3_r[NW-1];
    den_n = neg3 ? -den3_r : den3_r;
    nt_n  = neg3 ? -nt3_r : nt3_r;
    ns_n  = neg3 ? -ns3_r : ns3_r;
    dmt   = den_n - nt_n;
    dms   = den_n - ns_n;
    hit_n = (den3_r != '0) && !nt_n[NW-1] && !dmt[NW-1] && !ns_n[NW-1] && !dms[NW-1]
            && !((nt_n == '0) && (ns_n == '0));
    sx    = mx0_r + mx1_r;
    sy    = my0_r + my1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[NV-2:0], in_valid};
      out_valid_r <= v_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dax_r  <= DW'(in_data.a1_x) - DW'(in_data.a0_x);
      day_r  <= DW'(in_data.a1_y) - DW'(in_data.a0_y);
      dbx_r  <= DW'(in_data.b1_x) - DW'(in_data.b0_x);
      dby_r  <= DW'(in_data.b1_y) - DW'(in_data.b0_y);
      ox_r   <= DW'(in_data.a0_x) - DW'(in_data.b0_x);
      oy_r   <= DW'(in_data.a0_y) - DW'(in_data.b0_y);
      a0x1_r <= in_data.a0_x;
      a0y1_r <= in_data.a0_y;

      p_dd0_r <= dby_r * dax_r;
      p_dd1_r <= dbx_r * day_r;
      p_t0_r  <= dbx_r * oy_r;
      p_t1_r  <= dby_r * ox_r;
      p_s0_r  <= dax_r * oy_r;
      p_s1_r  <= day_r * ox_r;
      dax2_r  <= dax_r;
      day2_r  <= day_r;
      a0x2_r  <= a0x1_r;
      a0y2_r  <= a0y1_r;

      den3_r <= NW'(p_dd0_r) - NW'(p_dd1_r);
      nt3_r  <= NW'(p_t0_r) - NW'(p_t1_r);
      ns3_r  <= NW'(p_s0_r) - NW'(p_s1_r);
      dax3_r <= dax2_r;
      day3_r <= day2_r;
      a0x3_r <= a0x2_r;
      a0y3_r <= a0y2_r;

      den4_r <= den_n;
      nt4_r  <= nt_n;
      hit4_r <= hit_n;
      dax4_r <= dax3_r;
      day4_r <= day3_r;
      a0x4_r <= a0x3_r;
      a0y4_r <= a0y3_r;

      mx0_r  <= XW'(a0x4_r) * XW'(den4_r);
      mx1_r  <= XW'(nt4_r) * XW'(dax4_r);
      my0_r  <= XW'(a0y4_r) * XW'(den4_r);
      my1_r  <= XW'(nt4_r) * XW'(day4_r);
      den5_r <= den4_r;
      hit5_r <= hit4_r;

      rx_r[0] <= sx[XW-1] ? XW'(-sx) : XW'(sx);
      ry_r[0] <= sy[XW-1] ? XW'(-sy) : XW'(sy);
      nx_r[0] <= sx[XW-1];
      ny_r[0] <= sy[XW-1];
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      dd_r[0] <= XW'(den5_r);
      hd_r[0] <= hit5_r;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    localparam int B = W - 1 - k;
    logic [XW-1:0] trial;
    logic          gex, gey;
    assign trial = dd_r[k] << B;
    assign gex   = rx_r[k] >= trial;
    assign gey   = ry_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[k+1] <= gex ? rx_r[k] - trial : rx_r[k];
        ry_r[k+1] <= gey ? ry_r[k] - trial : ry_r[k];
        qx_r[k+1] <= qx_r[k] | (W'(gex) << B);
        qy_r[k+1] <= qy_r[k] | (W'(gey) << B);
        dd_r[k+1] <= dd_r[k];
        nx_r[k+1] <= nx_r[k];
        ny_r[k+1] <= ny_r[k];
        hd_r[k+1] <= hd_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.hit     <= hd_r[W];
      out_r.cross_x <= !hd_r[W] ? '0 : (nx_r[W] ? -qx_r[W] : qx_r[W]);
      out_r.cross_y <= !hd_r[W] ? '0 : (ny_r[W] ? -qy_r[W] : qy_r[W]);
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb
  import sip_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 3000;
  localparam int NumRandom  = 880;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sip_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sip_out_t out_data;

  sip_in_t  seg_pairs[$];
  sip_out_t point_q[$];
  logic     in_fire = 1'b0;
  int       gap_cnt = 0;
  int       hold_cnt = 0;
  int       idle_cycles = 0;
  int       errors = 0;
  bit       quiet = 1'b0;
  bit       choke_req = 1'b0;

  segment_intersection_point_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sip_out_t intersect_point(sip_in_t s);
    sip_out_t r;
    longint dax, day, dbx, dby, ox, oy, den, nt, ns;
    r = '0;
    dax = longint'(s.a1_x) - longint'(s.a0_x);
    day = longint'(s.a1_y) - longint'(s.a0_y);
    dbx = longint'(s.b1_x) - longint'(s.b0_x);
    dby = longint'(s.b1_y) - longint'(s.b0_y);
    ox  = longint'(s.a0_x) - longint'(s.b0_x);
    oy  = longint'(s.a0_y) - longint'(s.b0_y);
    den = dby * dax - dbx * day;
    if (den == 0) return r;
    nt = dbx * oy - dby * ox;
    ns = dax * oy - day * ox;
    if (den < 0) begin
      den = -den;
      nt  = -nt;
      ns  = -ns;
    end
    if (nt < 0 || nt > den || ns < 0 || ns > den) return r;
    if (nt == 0 && ns == 0) return r;
    r.hit     = 1'b1;
    r.cross_x = 16'((longint'(s.a0_x) * den + nt * dax) / den);
    r.cross_y = 16'((longint'(s.a0_y) * den + nt * day) / den);
    return r;
  endfunction

  function automatic sip_in_t seg(int ax0, int ay0, int ax1, int ay1,
                                  int bx0, int by0, int bx1, int by1);
    sip_in_t s;
    s.a0_x = 16'(ax0); s.a0_y = 16'(ay0); s.a1_x = 16'(ax1); s.a1_y = 16'(ay1);
    s.b0_x = 16'(bx0); s.b0_y = 16'(by0); s.b1_x = 16'(bx1); s.b1_y = 16'(by1);
    return s;
  endfunction

  function automatic int near_coord(int c, int span);
    return c + $urandom_range(2 * span) - span;
  endfunction

  function automatic sip_in_t random_pair();
    sip_in_t s;
    int k, cx, cy, span, dx, dy;
    k = $urandom_range(99);
    s = sip_in_t'({$urandom, $urandom, $urandom, $urandom});
    if (k < 60) begin
      span = (k < 30) ? 8 : 300;
      cx = $urandom_range(60000) - 30000;
      cy = $urandom_range(60000) - 30000;
      s = seg(near_coord(cx, span), near_coord(cy, span), near_coord(cx, span),
              near_coord(cy, span), near_coord(cx, span), near_coord(cy, span),
              near_coord(cx, span), near_coord(cy, span));
    end else if (k < 70) begin
      dx = $urandom_range(40) - 20;
      dy = $urandom_range(40) - 20;
      cx = $urandom_range(60000) - 30000;
      cy = $urandom_range(60000) - 30000;
      s = seg(cx, cy, cx + dx, cy + dy, cx + dx * 2, cy + dy * 2,
              cx - dx, cy - dy);
      if (k < 65) s.b0_x = s.b0_x + 16'($urandom_range(3));
    end else if (k < 80) begin
      s.a0_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.a1_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.b0_y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.b1_y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end else if (k < 85) begin
      s.b0_x = s.a0_x;
      s.b0_y = s.a0_y;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) point_q.push_back(intersect_point(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (point_q.size() == 0) begin
        $error("unexpected result hit=%0b x=%0d y=%0d", out_data.hit,
               out_data.cross_x, out_data.cross_y);
        errors++;
      end else begin
        if (out_data.hit !== point_q[0].hit) begin
          $error("hit: expected %0b actual %0b", point_q[0].hit, out_data.hit);
          errors++;
        end
        if (out_data.cross_x !== point_q[0].cross_x) begin
          $error("cross_x: expected %0d actual %0d", point_q[0].cross_x,
                 out_data.cross_x);
          errors++;
        end
        if (out_data.cross_y !== point_q[0].cross_y) begin
          $error("cross_y: expected %0d actual %0d", point_q[0].cross_y,
                 out_data.cross_y);
          errors++;
        end
        void'(point_q.pop_front());
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (gap_cnt > 0) begin
        in_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (rst_n && seg_pairs.size() > 0) begin
        in_data <= seg_pairs.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(7) == 0) gap_cnt <= $urandom_range(10, 1);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (choke_req && hold_cnt == 0) begin
      hold_cnt <= 300;
      choke_req <= 1'b0;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= ($urandom_range(4) != 0);
    end else begin
      out_stall <= ($urandom_range(9) == 0);
    end
  end

  initial begin
    seg_pairs.push_back(seg(0, 0, 10, 10, 0, 10, 10, 0));
    seg_pairs.push_back(seg(0, 0, 10, 0, 0, 5, 10, 5));
    seg_pairs.push_back(seg(0, 0, 10, 0, 2, 0, 20, 0));
    seg_pairs.push_back(seg(3, 3, 3, 3, 0, 0, 9, 9));
    seg_pairs.push_back(seg(0, 0, 10, 0, 10, 0, 10, 9));
    seg_pairs.push_back(seg(0, 0, 10, 0, 5, 0, 5, 9));
    seg_pairs.push_back(seg(0, 0, 10, 0, 0, 0, 0, 9));
    seg_pairs.push_back(seg(0, 0, 10, 0, 5, 1, 5, 9));
    seg_pairs.push_back(seg(0, 0, 10, 0, 20, -5, 20, 5));
    seg_pairs.push_back(seg(0, 0, 3, 7, 0, 7, 3, 0));
    seg_pairs.push_back(seg(0, 0, -3, -7, 0, -7, -3, 0));
    seg_pairs.push_back(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    seg_pairs.push_back(seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    seg_pairs.push_back(seg(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
    seg_pairs.push_back(seg(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32767));
    seg_pairs.push_back(seg(-32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767));
    seg_pairs.push_back(seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    seg_pairs.push_back(seg(-32768, -32768, -32768, -32768, 0, 0, 0, 0));
    seg_pairs.push_back(seg(-1, -1, 1, 2, 1, -1, -2, 1));
    seg_pairs.push_back(seg(100, 0, -100, 1, 0, 50, 1, -50));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (seg_pairs.size() == 0 && !in_valid);
    wait (point_q.size() == 0);
    for (int i = 0; i < NumRandom; i++) begin
      seg_pairs.push_back(random_pair());
      if (i == 300) choke_req = 1'b1;
    end
    wait (seg_pairs.size() < 600);
    wait (seg_pairs.size() == 0 || seg_pairs.size() < 580);
    wait (seg_pairs.size() < 120);
    quiet = 1'b1;
    wait (seg_pairs.size() == 0 && !in_valid);
    wait (point_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && point_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    wait (seg_pairs.size() > 0 && seg_pairs.size() < 700);
    @(negedge clk);
    choke_req = 1'b1;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/sip_pkg.sv
rtl/core/segment_intersection_point_unit.sv
sim/tb.sv
